@@ hw/rtl/acoustic_diversity_index_top_macros.svh @@
// Assertion macros for the acoustic diversity index block.
// Used by the port-level checker; no other dependencies.
`ifndef ACOUSTIC_DIVERSITY_INDEX_TOP_MACROS_SVH
`define ACOUSTIC_DIVERSITY_INDEX_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ADI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ADI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hw/rtl/adi_pkg.sv @@
// Package for the acoustic diversity index block: sizes, codes and the ln table.
// No dependencies.
package adi_pkg;
  localparam int N_BANDS = 8;
  localparam int BAND_BIN_COUNT = 64;
  localparam int LN_TABLE_DEPTH = 1024;
  localparam int TOTAL_BINS = N_BANDS * BAND_BIN_COUNT;
  localparam int BAND_W = (N_BANDS > 1) ? $clog2(N_BANDS) : 1;
  localparam int POS_W = $clog2(TOTAL_BINS + 1);
  localparam int LN_IDX_W = $clog2(LN_TABLE_DEPTH);
  localparam int BPB_W = $clog2(BAND_BIN_COUNT + 1);
  localparam int HIT_W = 38;
  localparam int FRAME_W = 32;
  localparam int DEN_W = FRAME_W + BPB_W;
  localparam int NUM_W = HIT_W + 17;
  localparam int IDX_W = 20;
  localparam logic [HIT_W-1:0] HIT_MAX = '1;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [IDX_W-1:0] INDEX_MAX = '1;
  localparam logic [15:0] THRESH_RESET = 16'd207;
  localparam logic CMD_BIN = 1'b0;
  localparam logic CMD_FINALIZE = 1'b1;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  function automatic logic [63:0] log2_q30(input logic [31:0] n);
    logic [31:0] p;
    logic [63:0] m, r;
    p = 0;
    for (int j = 0; j < 31; j++) if ((n >> (p + 1)) != 0) p = p + 1;
    m = {32'd0, n} << (30 - ((p > 30) ? 30 : p));
    r = {32'd0, p} << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << i);
      end
    end
    return r;
  endfunction

  typedef logic [IDX_W-1:0] ln_tab_t [LN_TABLE_DEPTH];

  function automatic ln_tab_t build_ln_tab();
    ln_tab_t t;
    logic [63:0] lden, lnum, d, v;
    lden = log2_q30(32'(2 * LN_TABLE_DEPTH));
    for (int k = 0; k < LN_TABLE_DEPTH; k++) begin
      lnum = log2_q30(32'(2 * k + 1));
      d = (lden > lnum) ? lden - lnum : 64'd0;
      v = (d * LN2_Q30 + (64'd1 << 43)) >> 44;
      t[k] = (v > 64'(INDEX_MAX)) ? INDEX_MAX : v[IDX_W-1:0];
    end
    return t;
  endfunction

  localparam ln_tab_t LN_TAB = build_ln_tab();
endpackage

@@ hw/rtl/adi_if.sv @@
// Valid/ready channel interfaces for the acoustic diversity index block.
// Depends on adi_pkg.
interface adi_in_if import adi_pkg::*; ();
  logic valid;
  logic ready;
  logic command;
  logic [15:0] magnitude;
  logic last_bin;
  modport source (output valid, command, magnitude, last_bin, input ready);
  modport sink (input valid, command, magnitude, last_bin, output ready);
endinterface

interface adi_out_if import adi_pkg::*; ();
  logic valid;
  logic ready;
  logic [IDX_W-1:0] diversity_index;
  logic no_frames;
  logic [FRAME_W-1:0] frames_used;
  modport source (output valid, diversity_index, no_frames, frames_used, input ready);
  modport sink (input valid, diversity_index, no_frames, frames_used, output ready);
endinterface

@@ hw/rtl/acoustic_diversity_index_top.sv @@
// Acoustic diversity index top level: bin counting, band walk and result register.
// Depends on adi_pkg and the channel interfaces in adi_if.sv.
//
// A bin transaction leaves the block idle and ready for the next bin.
// A finalize walks the bands one after another through one shared restoring
// divider (one dividend bit per cycle) and one shared multiplier for the ln
// term, which an empty or full band skips; the result then waits in the
// output register until taken, and the block accepts bins again at once.
// A further finalize waits until the previous result has been taken.
module acoustic_diversity_index_top import adi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  adi_in_if.sink in_ch,
  adi_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_LOOK = 3'd2,
                         S_MUL = 3'd3, S_ACC = 3'd4, S_DONE = 3'd5;

  logic [15:0] thresh_r;
  logic [HIT_W-1:0] hits_r [N_BANDS];
  logic [FRAME_W-1:0] frames_r;
  logic [POS_W-1:0] pos_r;
  logic [2:0] state_r;
  logic [BAND_W-1:0] band_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0] rem_r;
  logic [16:0] quo_r;
  logic [5:0] bit_r;
  logic [IDX_W-1:0] ln_r;
  logic [36:0] prod_r;
  logic [IDX_W+BAND_W:0] sum_r;
  logic out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic out_nf_r;
  logic [FRAME_W-1:0] out_fr_r;

  logic in_fire, busy;
  logic [BAND_W-1:0] cur_band;
  logic [DEN_W:0] rem_sh;
  logic [DEN_W+1:0] den_x;
  logic [DEN_W-1:0] den_init;
  logic [LN_IDX_W+16:0] lidx;

  assign busy = (state_r != S_IDLE);
  assign in_ch.ready = !busy && !(in_ch.command == CMD_FINALIZE && out_valid_r);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cur_band = BAND_W'(pos_r / BAND_BIN_COUNT);
  // Dividend bits stream in from the top; the 17 quotient bits come last.
  assign rem_sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
  assign den_x = {2'b0, den_r};
  assign den_init = DEN_W'(frames_r) * DEN_W'(BAND_BIN_COUNT);
  assign lidx = (LN_IDX_W + 17)'(quo_r) * (LN_IDX_W + 17)'(LN_TABLE_DEPTH);

  assign out_ch.valid = out_valid_r;
  assign out_ch.diversity_index = out_idx_r;
  assign out_ch.no_frames = out_nf_r;
  assign out_ch.frames_used = out_fr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      frames_r <= '0;
      pos_r <= '0;
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N_BANDS; i++) hits_r[i] <= '0;
    end else begin
      if (cfg_we) thresh_r <= cfg_wdata;
      if (out_ch.valid && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.command == CMD_BIN && frames_r != FRAME_MAX) begin
            if (POS_W'(TOTAL_BINS) > pos_r && in_ch.magnitude > thresh_r &&
                hits_r[cur_band] != HIT_MAX)
              hits_r[cur_band] <= hits_r[cur_band] + 1'b1;
            if (in_ch.last_bin) begin
              frames_r <= frames_r + 1'b1;
              pos_r <= '0;
            end else if (POS_W'(TOTAL_BINS) > pos_r) begin
              pos_r <= pos_r + 1'b1;
            end
          end else if (in_fire && in_ch.command == CMD_FINALIZE) begin
            if (frames_r == '0) begin
              out_valid_r <= 1'b1;
              out_idx_r <= '0;
              out_nf_r <= 1'b1;
              out_fr_r <= '0;
              pos_r <= '0;
              for (int i = 0; i < N_BANDS; i++) hits_r[i] <= '0;
            end else begin
              band_r <= '0;
              sum_r <= '0;
              state_r <= S_DIV;
              den_r <= den_init;
              // hits*65536 + den/2, shifted through the divider MSB first.
              num_r <= NUM_W'({hits_r[0], 16'd0}) + NUM_W'(den_init >> 1);
              rem_r <= '0;
              bit_r <= 6'(NUM_W - 1);
            end
          end
        end
        S_DIV: begin
          if ({1'b0, rem_sh} >= den_x) rem_r <= (DEN_W+1)'(({1'b0, rem_sh} - den_x));
          else rem_r <= rem_sh;
          quo_r <= {quo_r[15:0], ({1'b0, rem_sh} >= den_x)};
          num_r <= num_r << 1;
          if (bit_r == '0) state_r <= S_LOOK;
          else bit_r <= bit_r - 1'b1;
        end
        S_LOOK: begin
          ln_r <= LN_TAB[lidx[LN_IDX_W+15:16]];
          state_r <= (quo_r == '0 || quo_r[16]) ? S_ACC : S_MUL;
          prod_r <= '0;
        end
        S_MUL: begin
          prod_r <= 37'(quo_r) * 37'(ln_r) + 37'd32768;
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_r + (IDX_W+BAND_W+1)'(prod_r[36:16]);
          if (band_r == BAND_W'(N_BANDS - 1)) state_r <= S_DONE;
          else begin
            band_r <= band_r + 1'b1;
            num_r <= NUM_W'({hits_r[band_r + 1'b1], 16'd0}) + NUM_W'(den_r >> 1);
            rem_r <= '0;
            bit_r <= 6'(NUM_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r <= (sum_r > (IDX_W+BAND_W+1)'(INDEX_MAX)) ? INDEX_MAX
                         : sum_r[IDX_W-1:0];
            out_nf_r <= 1'b0;
            out_fr_r <= frames_r;
            frames_r <= '0;
            pos_r <= '0;
            for (int i = 0; i < N_BANDS; i++) hits_r[i] <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/adi_checker.sv @@
// Port-level checker for the acoustic diversity index block, with its bind.
// Depends on adi_pkg and acoustic_diversity_index_top_macros.svh.
`include "acoustic_diversity_index_top_macros.svh"
module adi_port_checker import adi_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic out_no_frames,
  input logic [IDX_W-1:0] out_diversity_index,
  input logic [FRAME_W-1:0] out_frames_used
);
  // A bin transaction never makes the block busy.
  `ADI_ASSERT(a_bin_ready, clk, rst_n, (in_valid && in_ready && in_command == CMD_BIN) |=> in_ready || out_valid, "block stalled after a bin")
  // No frames means a zero index and a zero count.
  `ADI_ASSERT(a_nf_zero, clk, rst_n, (out_valid && out_no_frames) |-> (out_diversity_index == '0 && out_frames_used == '0), "no_frames result not zero")
  // A counted result reports at least one frame.
  `ADI_ASSERT(a_fr_nonzero, clk, rst_n, (out_valid && !out_no_frames) |-> (out_frames_used != '0), "result with zero frames")
  // A stalled result holds.
  `ADI_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_diversity_index)), "result changed while stalled")
endmodule

bind acoustic_diversity_index_top adi_port_checker u_adi_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_no_frames(out_ch.no_frames), .out_diversity_index(out_ch.diversity_index),
  .out_frames_used(out_ch.frames_used)
);

@@ sim/adi_checker.sv @@
`timescale 1ns / 1ps
// Checker for the acoustic diversity index block: watches both channels and the
// threshold register port, predicts every index result and compares.
// Depends on adi_pkg, adi_if.sv.
module adi_checker import adi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  adi_in_if in_ch,
  adi_out_if out_ch,
  output int fail_count,
  output int pending
);
  typedef struct {
    logic [IDX_W-1:0] index;
    logic no_frames;
    logic [FRAME_W-1:0] frames;
  } index_result_t;

  index_result_t expected_index_q[$];
  logic [IDX_W-1:0] neg_ln [LN_TABLE_DEPTH];
  logic [HIT_W-1:0] hits [N_BANDS];
  logic [FRAME_W-1:0] frames;
  int unsigned bin_pos;
  logic [15:0] threshold;

  assign pending = expected_index_q.size();

  // log2 of n >= 1: integer part over 30 fraction bits, by repeated squaring.
  function automatic logic [63:0] log2_fix(input int unsigned n);
    int unsigned msb;
    logic [63:0] m, r;
    msb = 0;
    while (msb < 31 && (n >> (msb + 1)) != 0) msb++;
    m = 64'(n) << (30 - msb);
    r = 64'(msb) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  initial begin
    logic [63:0] lden, lnum, d, v;
    fail_count = 0;
    lden = log2_fix(2 * LN_TABLE_DEPTH);
    for (int k = 0; k < LN_TABLE_DEPTH; k++) begin
      lnum = log2_fix(2 * k + 1);
      d = (lden > lnum) ? lden - lnum : 64'd0;
      v = (d * 64'd744261118 + (64'd1 << 43)) >> 44;
      neg_ln[k] = (v > 64'hFFFFF) ? '1 : v[IDX_W-1:0];
    end
  end

  task automatic clear_counts();
    foreach (hits[i]) hits[i] = '0;
    frames = '0;
    bin_pos = 0;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic count_bin(input logic [15:0] mag, input logic last);
    if (frames == FRAME_MAX) return;
    if (bin_pos < TOTAL_BINS) begin
      if (mag > threshold && hits[bin_pos / BAND_BIN_COUNT] != HIT_MAX)
        hits[bin_pos / BAND_BIN_COUNT]++;
      bin_pos++;
    end
    if (last) begin
      frames++;
      bin_pos = 0;
    end
  endtask

  task automatic finalize();
    index_result_t res;
    logic [63:0] den, b, sum;
    int unsigned slot;
    res.no_frames = (frames == 0);
    res.frames = frames;
    sum = 0;
    if (frames != 0) begin
      den = 64'(BAND_BIN_COUNT) * 64'(frames);
      foreach (hits[i]) begin
        b = ((64'(hits[i]) << 16) + (den >> 1)) / den;
        // Empty and full bands add nothing.
        if (b == 0 || b >= 65536) continue;
        slot = (b * LN_TABLE_DEPTH) >> 16;
        sum += (b * neg_ln[slot] + 64'd32768) >> 16;
      end
    end
    res.index = (sum > 64'hFFFFF) ? '1 : sum[IDX_W-1:0];
    expected_index_q.push_back(res);
    clear_counts();
  endtask

  always @(posedge clk) begin
    index_result_t want;
    if (!rst_n) begin
      clear_counts();
      threshold = THRESH_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_index_q.size() == 0) begin
          report("unexpected result transaction", 64'd1, 64'd0);
        end else begin
          want = expected_index_q.pop_front();
          if (out_ch.diversity_index !== want.index)
            report("diversity_index", out_ch.diversity_index, want.index);
          if (out_ch.no_frames !== want.no_frames)
            report("no_frames", out_ch.no_frames, want.no_frames);
          if (out_ch.frames_used !== want.frames)
            report("frames_used", out_ch.frames_used, want.frames);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_FINALIZE) finalize();
        else count_bin(in_ch.magnitude, in_ch.last_bin);
      end
      if (cfg_we) threshold = cfg_wdata;
    end
  end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the acoustic diversity index testbench: clock, reset, stimulus and verdict.
// Depends on adi_pkg, adi_if.sv, the block and adi_checker.sv.
module testbench;
  import adi_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 200;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  int fail_count, pending;
  int snd_idle, rcv_idle;
  int quiet_cycles = 0;
  int sent;
  logic [15:0] threshold;

  adi_in_if in_ch ();
  adi_out_if out_ch ();

  acoustic_diversity_index_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  adi_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.command = CMD_BIN;
    in_ch.magnitude = '0;
    in_ch.last_bin = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(input logic cmd, input logic [15:0] mag, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.command = cmd;
    in_ch.magnitude = mag;
    in_ch.last_bin = last;
    // The handshake is judged on the ready value seen at the edge itself.
    @(posedge clk iff in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [15:0] pick_magnitude();
    int near;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        near = int'(threshold) + $urandom_range(4) - 2;
        return (near < 0) ? 16'd0 : (near > 65535) ? 16'hFFFF : 16'(near);
      end
      2: return 16'($urandom_range(400));
      default: return $urandom_range(1) ? 16'hFFFF : 16'd0;
    endcase
  endfunction

  // One frame of random length; most are short, a few run past the last band.
  task automatic send_frame(input bit finish);
    int len;
    len = ($urandom_range(19) == 0) ? $urandom_range(TOTAL_BINS + 80, TOTAL_BINS + 1)
                                    : $urandom_range(40, 1);
    for (int i = 0; i < len; i++)
      send(CMD_BIN, pick_magnitude(), finish && (i == len - 1));
  endtask

  task automatic drain_and_write(input logic [15:0] value);
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = value;
    threshold = value;
    @(negedge clk);
    cfg_we = 0;
  endtask

  initial begin
    logic [15:0] phase_threshold [6];
    phase_threshold = '{16'd0, 16'hFFFF, 16'd207, 16'd1, 16'hFFFE, 16'd0};
    phase_threshold[5] = 16'($urandom);
    snd_idle = 33;
    rcv_idle = 51;
    sent = 0;
    threshold = THRESH_RESET;
    repeat (2) @(negedge clk);
    rst_n = 1;

    // Directed part at the reset threshold: empty finalize, threshold edges,
    // a full first band, and an unfinished frame.
    send(CMD_FINALIZE, 16'hFFFF, 1);
    send(CMD_BIN, 16'd207, 0);
    send(CMD_BIN, 16'd208, 0);
    send(CMD_BIN, 16'd0, 0);
    send(CMD_BIN, 16'hFFFF, 1);
    send(CMD_FINALIZE, 16'd0, 0);
    for (int i = 0; i < 64; i++) send(CMD_BIN, 16'hFFFF, i == 63);
    send(CMD_BIN, 16'hFFFF, 0);
    send(CMD_BIN, 16'h8000, 0);
    send(CMD_FINALIZE, 16'h5555, 0);
    send(CMD_FINALIZE, 16'hAAAA, 1);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        snd_idle = 51;
        rcv_idle = 33;
      end else if (phase == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      drain_and_write(phase_threshold[phase]);
      sent = 0;
      while (sent < 160) begin
        repeat ($urandom_range(3, 1)) send_frame(1);
        if ($urandom_range(4) == 0) send_frame(0);
        send(CMD_FINALIZE, 16'($urandom), 1'($urandom));
      end
    end

    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
